>>> design/mtpm_pkg.sv
// Package with the shared types and codes of the multibit trie prefix match block.
`timescale 1ns / 1ps

package mtpm_pkg;

   localparam logic [1:0] ST_INSERT_OK  = 2'd0;
   localparam logic [1:0] ST_POOL_FULL  = 2'd1;
   localparam logic [1:0] ST_SEARCH_HIT = 2'd2;
   localparam logic [1:0] ST_SEARCH_MISS = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LINK_RD,
      S_LINK_EV,
      S_MARK_EV,
      S_CHECK,
      S_ALLOC,
      S_MARK_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic clr_wr;
      logic link_adv;
      logic mark_take;
      logic set_full;
      logic alloc_wr;
      logic finish_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic link_zero;
      logic walk_end;
      logic pool_ok;
      logic is_search;
      logic rsp_free;
   } stat_type;

endpackage

>>> design/mtpm_controller.sv
// Sequencer that steps one request through the trie walk, allocation and response.
`timescale 1ns / 1ps

module mtpm_controller
   import mtpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LINK_RD;
            end
         end
         S_LINK_RD: begin
            if (stat.walk_end) begin
               state_in = stat.is_search ? S_RESP : S_CHECK;
            end else begin
               state_in = S_LINK_EV;
            end
         end
         S_LINK_EV: begin
            if (stat.link_zero) begin
               state_in = stat.is_search ? S_RESP : S_CHECK;
            end else begin
               cmd.link_adv = 1'b1;
               state_in = stat.is_search ? S_MARK_EV : S_LINK_RD;
            end
         end
         S_MARK_EV: begin
            cmd.mark_take = 1'b1;
            state_in = S_LINK_RD;
         end
         S_CHECK: begin
            if (stat.pool_ok) begin
               state_in = S_ALLOC;
            end else begin
               cmd.set_full = 1'b1;
               state_in = S_RESP;
            end
         end
         S_ALLOC: begin
            if (stat.walk_end) begin
               state_in = S_MARK_WR;
            end else begin
               cmd.alloc_wr = 1'b1;
            end
         end
         S_MARK_WR: begin
            cmd.finish_wr = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

>>> design/mtpm_datapath.sv
// Datapath with the child table, node marks, server ids, walk registers and response register.
`timescale 1ns / 1ps

module mtpm_datapath
   import mtpm_pkg::*;
#(
   parameter int NODE_POOL = 256,
   parameter int KEY_BYTES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output stat_type     stat,
   input  logic         req_operation,
   input  logic [63:0]  req_key_high,
   input  logic [63:0]  req_key_low,
   input  logic [7:0]   req_prefix_len,
   input  logic [63:0]  req_server_high,
   input  logic [63:0]  req_server_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_match_high,
   output logic [63:0]  rsp_match_low
);

   localparam int NW    = $clog2(NODE_POOL);
   localparam int UW    = $clog2(NODE_POOL + 1);
   localparam int AW    = NW + 8;
   localparam int LW    = $clog2(KEY_BYTES + 1);
   localparam int DEPTH = NODE_POOL * 256;

   logic [NW-1:0]  child_mem [DEPTH];
   logic           mark_mem [NODE_POOL];
   logic [127:0]   server_mem [NODE_POOL];

   logic           op_ff;
   logic [127:0]   key_ff;
   logic [LW-1:0]  depth_ff, level_ff;
   logic [NW-1:0]  node_ff;
   logic [127:0]   server_ff;
   logic           hit_ff, full_ff;
   logic [127:0]   match_ff;
   logic [UW-1:0]  used_ff;
   logic [AW-1:0]  clr_ff;
   logic [NW-1:0]  child_rd_ff;
   logic           mark_rd_ff;
   logic [127:0]   server_rd_ff;
   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff;
   logic [127:0]   rsp_match_ff;

   logic [4:0]     plen_bytes;
   logic [LW-1:0]  depth_in;
   logic [LW-1:0]  need;
   logic [UW-1:0]  free_nodes;
   logic [AW-1:0]  link_addr;
   logic [1:0]     status_in;

   assign plen_bytes = req_prefix_len[7:3];
   assign depth_in   = (req_operation == OP_SEARCH) ? LW'(KEY_BYTES) :
                       (plen_bytes > 5'(KEY_BYTES)) ? LW'(KEY_BYTES) : LW'(plen_bytes);
   assign need       = depth_ff - level_ff;
   assign free_nodes = UW'(NODE_POOL) - used_ff;
   assign link_addr  = {node_ff, key_ff[127:120]};

   always_comb begin
      if (op_ff == OP_SEARCH) begin
         status_in = hit_ff ? ST_SEARCH_HIT : ST_SEARCH_MISS;
      end else begin
         status_in = full_ff ? ST_POOL_FULL : ST_INSERT_OK;
      end
   end

   assign stat.clr_last  = (clr_ff == AW'(DEPTH - 1));
   assign stat.link_zero = (child_rd_ff == '0);
   assign stat.walk_end  = (level_ff == depth_ff);
   assign stat.pool_ok   = (UW'(need) <= free_nodes);
   assign stat.is_search = op_ff;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         child_mem[clr_ff] <= '0;
      end else if (cmd.alloc_wr) begin
         child_mem[link_addr] <= used_ff[NW-1:0];
      end
      child_rd_ff <= child_mem[link_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_wr && (clr_ff < AW'(NODE_POOL))) begin
         mark_mem[clr_ff[NW-1:0]] <= 1'b0;
      end else if (cmd.finish_wr) begin
         mark_mem[node_ff] <= 1'b1;
      end
      mark_rd_ff <= mark_mem[child_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_wr) begin
         server_mem[node_ff] <= server_ff;
      end
      server_rd_ff <= server_mem[child_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         used_ff      <= UW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.alloc_wr) begin
            used_ff <= used_ff + UW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         key_ff    <= {req_key_high, req_key_low};
         depth_ff  <= depth_in;
         level_ff  <= '0;
         node_ff   <= '0;
         server_ff <= {req_server_high, req_server_low};
         hit_ff    <= 1'b0;
         full_ff   <= 1'b0;
         match_ff  <= '0;
      end else begin
         if (cmd.link_adv) begin
            node_ff  <= child_rd_ff;
            key_ff   <= {key_ff[119:0], 8'h00};
            level_ff <= level_ff + LW'(1);
         end
         if (cmd.alloc_wr) begin
            node_ff  <= used_ff[NW-1:0];
            key_ff   <= {key_ff[119:0], 8'h00};
            level_ff <= level_ff + LW'(1);
         end
         if (cmd.mark_take && mark_rd_ff) begin
            hit_ff   <= 1'b1;
            match_ff <= server_rd_ff;
         end
         if (cmd.set_full) begin
            full_ff <= 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_match_ff  <= match_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_match_high = rsp_match_ff[127:64];
   assign rsp_match_low  = rsp_match_ff[63:0];

   // The node count never passes the pool size.
   assert property (@(posedge clock) disable iff (reset) used_ff <= UW'(NODE_POOL))
      else $error("node count exceeds the pool");

   // A node is allocated only while the pool still has a free node.
   assert property (@(posedge clock) disable iff (reset) cmd.alloc_wr |-> used_ff < UW'(NODE_POOL))
      else $error("allocation from an exhausted pool");

   // A pool-full request leaves the node count unchanged.
   assert property (@(posedge clock) disable iff (reset) cmd.set_full |=> $stable(used_ff))
      else $error("node count changed on a full pool");

endmodule

>>> design/multibit_trie_prefix_match_top.sv
// Top level of the multibit trie longest prefix match block.
//
//   channel   direction   ports
//   req       in          req_valid, req_stall, operation, key, prefix length, server id
//   rsp       out         rsp_valid, rsp_stall, status, match id
//
// One request at a time. A search reads the child table and then the node mark at each
// trie level visited; an insert walks the existing levels, checks the free node count,
// allocates one new node per missing level and writes the mark and server id.
// The child table is read serially, one level per walk step.
// After reset the child table and node marks are cleared, one entry a cycle, before the
// first request is taken. A finished response waits in the output register while the
// next request is accepted.
`timescale 1ns / 1ps

module multibit_trie_prefix_match_top
   import mtpm_pkg::*;
#(
   parameter int NODE_POOL = 256,
   parameter int KEY_BYTES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_operation,
   input  logic [63:0]  req_key_high,
   input  logic [63:0]  req_key_low,
   input  logic [7:0]   req_prefix_len,
   input  logic [63:0]  req_server_high,
   input  logic [63:0]  req_server_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_match_high,
   output logic [63:0]  rsp_match_low
);

   cmd_type  cmd;
   stat_type stat;

   mtpm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtpm_datapath #(
      .NODE_POOL (NODE_POOL),
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_key_high    (req_key_high),
      .req_key_low     (req_key_low),
      .req_prefix_len  (req_prefix_len),
      .req_server_high (req_server_high),
      .req_server_low  (req_server_low),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_match_high  (rsp_match_high),
      .rsp_match_low   (rsp_match_low)
   );

endmodule
